### rtl/u8n1_pkg.sv
// Shared types and constants for the 8N1 UART transceiver.
// Used by u8n1_tx, u8n1_rx and uart_8n1_transceiver; no dependencies.
package u8n1_pkg;

	typedef enum logic [1:0] {
		TX_IDLE  = 2'd0,
		TX_START = 2'd1,
		TX_DATA  = 2'd2,
		TX_STOP  = 2'd3
	} tx_phase_t;

	typedef enum logic [2:0] {
		RX_SYNC  = 3'd0,
		RX_IDLE  = 3'd1,
		RX_START = 3'd2,
		RX_HALF  = 3'd3,
		RX_DATA  = 3'd4,
		RX_STOP  = 3'd5,
		RX_TAIL  = 3'd6
	} rx_phase_t;

	typedef struct packed {
		logic line;
		logic busy;
	} tx_res_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       stop_bad;
		logic       busy;
	} rx_res_t;

	localparam int         ADDR_W            = 3;
	localparam logic       IDX_BIT_PERIOD    = 1'b0;
	localparam logic       IDX_RX_SYNC_EN    = 1'b1;
	localparam logic [15:0] BIT_PERIOD_RESET = 16'd104;
	localparam logic       RX_SYNC_EN_RESET  = 1'b1;

endpackage

### rtl/u8n1_tx.sv
// Transmit framer: start bit, data bits LSB first, stop bit, one bit period each.
// Depends on u8n1_pkg; advances one tick per step.
module u8n1_tx #(
	parameter int DATA_BITS        = 8,
	parameter int TICK_COUNT_WIDTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic                        send_valid,
	input  logic [7:0]                  send_byte,
	input  logic [TICK_COUNT_WIDTH-1:0] period,
	output u8n1_pkg::tx_res_t           res
);
	localparam int BW = $clog2(DATA_BITS + 1);
	localparam logic [BW-1:0] BIT_LAST = BW'(DATA_BITS);

	u8n1_pkg::tx_phase_t         phase_q, phase_n;
	logic [TICK_COUNT_WIDTH-1:0] cnt_q, cnt_n, cnt_inc;
	logic [BW-1:0]               bit_q, bit_n;
	logic [DATA_BITS-1:0]        shift_q, shift_n;
	logic                        done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= u8n1_pkg::TX_IDLE;
			cnt_q   <= '0;
			bit_q   <= '0;
			shift_q <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			bit_q   <= bit_n;
			shift_q <= shift_n;
		end
	end

	assign cnt_inc = cnt_q + 1'b1;
	assign done    = (cnt_inc >= period) || (cnt_inc == '0);

	always_comb begin
		phase_n = phase_q;
		cnt_n   = cnt_q;
		bit_n   = bit_q;
		shift_n = shift_q;
		case (phase_q)
			u8n1_pkg::TX_IDLE: begin
				if (send_valid) begin
					phase_n = u8n1_pkg::TX_START;
					cnt_n   = '0;
					bit_n   = '0;
					shift_n = DATA_BITS'(send_byte);
				end
			end
			u8n1_pkg::TX_START: begin
				if (done) begin
					cnt_n   = '0;
					bit_n   = '0;
					phase_n = u8n1_pkg::TX_DATA;
				end else begin
					cnt_n = cnt_inc;
				end
			end
			u8n1_pkg::TX_DATA: begin
				if (done) begin
					cnt_n   = '0;
					shift_n = shift_q >> 1;
					bit_n   = bit_q + 1'b1;
					if (bit_n >= BIT_LAST)
						phase_n = u8n1_pkg::TX_STOP;
				end else begin
					cnt_n = cnt_inc;
				end
			end
			u8n1_pkg::TX_STOP: begin
				if (done) begin
					cnt_n   = '0;
					phase_n = u8n1_pkg::TX_IDLE;
				end else begin
					cnt_n = cnt_inc;
				end
			end
			default: begin
				phase_n = u8n1_pkg::TX_IDLE;
				cnt_n   = '0;
			end
		endcase

		case (phase_n)
			u8n1_pkg::TX_START: res.line = 1'b0;
			u8n1_pkg::TX_DATA:  res.line = shift_n[0];
			default:            res.line = 1'b1;
		endcase
		res.busy = (phase_n != u8n1_pkg::TX_IDLE);
	end

endmodule

### rtl/u8n1_rx.sv
// Receive deframer: idle hunt, start edge, mid-bit sampling, stop check, tail wait.
// Depends on u8n1_pkg; advances one tick per step.
module u8n1_rx #(
	parameter int DATA_BITS        = 8,
	parameter int TICK_COUNT_WIDTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic                        rx_line,
	input  logic                        sync_en,
	input  logic [TICK_COUNT_WIDTH-1:0] period,
	output u8n1_pkg::rx_res_t           res
);
	localparam int BW = $clog2(DATA_BITS + 1);
	localparam logic [BW-1:0] BIT_LAST = BW'(DATA_BITS);
	localparam u8n1_pkg::rx_phase_t RX_RESET_PHASE =
		u8n1_pkg::RX_SYNC_EN_RESET ? u8n1_pkg::RX_SYNC : u8n1_pkg::RX_IDLE;

	u8n1_pkg::rx_phase_t         phase_q, phase_n, ph;
	logic [TICK_COUNT_WIDTH-1:0] cnt_q, cnt_n, cnt, cnt_inc, target, half;
	logic [TICK_COUNT_WIDTH:0]   sync_inc;
	logic [BW-1:0]               bit_q, bit_n;
	logic [DATA_BITS-1:0]        shift_q, shift_n;
	logic                        done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= RX_RESET_PHASE;
			cnt_q   <= '0;
			bit_q   <= '0;
			shift_q <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			bit_q   <= bit_n;
			shift_q <= shift_n;
		end
	end

	assign half     = period >> 1;
	assign sync_inc = {1'b0, cnt_q} + 1'b1;

	always_comb begin
		// idle hunt resolves first; leaving it lets the same tick act as idle
		ph  = phase_q;
		cnt = cnt_q;
		if (phase_q == u8n1_pkg::RX_SYNC) begin
			if (!sync_en) begin
				ph  = u8n1_pkg::RX_IDLE;
				cnt = '0;
			end else if (rx_line) begin
				if (sync_inc > {1'b0, period}) begin
					ph  = u8n1_pkg::RX_IDLE;
					cnt = '0;
				end else begin
					cnt = sync_inc[TICK_COUNT_WIDTH-1:0];
				end
			end else begin
				cnt = '0;
			end
		end

		target  = (ph == u8n1_pkg::RX_HALF || ph == u8n1_pkg::RX_TAIL) ? half : period;
		cnt_inc = cnt + 1'b1;
		done    = (cnt_inc >= target) || (cnt_inc == '0);

		phase_n      = ph;
		cnt_n        = cnt;
		bit_n        = bit_q;
		shift_n      = shift_q;
		res.valid    = 1'b0;
		res.data     = '0;
		res.stop_bad = 1'b0;

		case (ph)
			u8n1_pkg::RX_SYNC: begin
				phase_n = u8n1_pkg::RX_SYNC;
			end
			u8n1_pkg::RX_IDLE: begin
				if (!rx_line) begin
					phase_n = u8n1_pkg::RX_START;
					cnt_n   = '0;
					bit_n   = '0;
					shift_n = '0;
				end
			end
			u8n1_pkg::RX_START: begin
				if (done) begin
					cnt_n   = '0;
					phase_n = u8n1_pkg::RX_HALF;
				end else begin
					cnt_n = cnt_inc;
				end
			end
			u8n1_pkg::RX_HALF, u8n1_pkg::RX_DATA: begin
				if (done) begin
					cnt_n   = '0;
					shift_n = {rx_line, shift_q[DATA_BITS-1:1]};
					bit_n   = bit_q + 1'b1;
					phase_n = (bit_n >= BIT_LAST) ? u8n1_pkg::RX_STOP : u8n1_pkg::RX_DATA;
				end else begin
					cnt_n = cnt_inc;
				end
			end
			u8n1_pkg::RX_STOP: begin
				if (done) begin
					cnt_n        = '0;
					res.valid    = 1'b1;
					res.stop_bad = !rx_line;
					res.data     = rx_line ? 8'(shift_q) : 8'h00;
					phase_n      = u8n1_pkg::RX_TAIL;
				end else begin
					cnt_n = cnt_inc;
				end
			end
			u8n1_pkg::RX_TAIL: begin
				if (done) begin
					cnt_n   = '0;
					phase_n = u8n1_pkg::RX_IDLE;
				end else begin
					cnt_n = cnt_inc;
				end
			end
			default: begin
				phase_n = u8n1_pkg::RX_IDLE;
				cnt_n   = '0;
			end
		endcase

		res.busy = (phase_n != u8n1_pkg::RX_SYNC) && (phase_n != u8n1_pkg::RX_IDLE);
	end

endmodule

### rtl/uart_8n1_transceiver.sv
// Top level of the 8N1 UART transceiver: input register, tx and rx framers,
// result register and APB register file. Depends on u8n1_pkg, u8n1_tx, u8n1_rx.
//
// Channel  | Dir | Handshake               | Payload
// ---------+-----+-------------------------+-----------------------------------------
// s_*      | in  | s_tvalid / s_tready     | s_tdata: one tick, line and send request
// m_*      | out | m_tvalid / m_tready     | m_tdata: tx/rx status after that tick
// apb      | in  | psel, penable, pready=1 | bit_period @0x0, rx_sync_enable @0x4
//
// One transaction per cycle in, one per cycle out, while the output is not stalled.
// The input register feeds the framers, whose update is registered with the result.
// A stalled output holds the result register and the input register behind it.
// arst_n clears both framers to idle (receiver in idle hunt) and the valid bits of the registers.
module uart_8n1_transceiver #(
	parameter int DATA_BITS        = 8,
	parameter int TICK_COUNT_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [15:0]                       s_tdata,  // rx_line, send_valid, send_byte[7:0], 0
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [15:0]                       m_tdata,  // tx_line, tx_busy, rx_valid,
	                                                    // rx_byte[7:0], rx_stop_bad, rx_busy, 0
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [u8n1_pkg::ADDR_W-1:0]       paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);
	logic                        valid_s1;
	logic [9:0]                  data_s1;
	logic                        out_valid_q;
	logic [15:0]                 out_data_q;
	logic                        advance, step, cfg_wr;
	logic [15:0]                 bit_period_q;
	logic                        sync_en_q;
	logic [TICK_COUNT_WIDTH-1:0] period;
	u8n1_pkg::tx_res_t           tx_res;
	u8n1_pkg::rx_res_t           rx_res;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = (paddr[2] == u8n1_pkg::IDX_RX_SYNC_EN) ? {31'd0, sync_en_q}
	                                                        : {16'd0, bit_period_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q <= u8n1_pkg::BIT_PERIOD_RESET;
			sync_en_q    <= u8n1_pkg::RX_SYNC_EN_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == u8n1_pkg::IDX_BIT_PERIOD)
				bit_period_q <= pwdata[15:0];
			else
				sync_en_q <= pwdata[0];
		end
	end

	assign period   = TICK_COUNT_WIDTH'(bit_period_q);
	assign advance  = !out_valid_q || m_tready;
	assign step     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (advance)
				out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			data_s1 <= s_tdata[9:0];
		if (step)
			out_data_q <= {3'd0, rx_res.busy, rx_res.stop_bad, rx_res.data,
			               rx_res.valid, tx_res.busy, tx_res.line};
	end

	u8n1_tx #(
		.DATA_BITS       (DATA_BITS),
		.TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)
	) u_tx (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.send_valid(data_s1[1]),
		.send_byte (data_s1[9:2]),
		.period    (period),
		.res       (tx_res)
	);

	u8n1_rx #(
		.DATA_BITS       (DATA_BITS),
		.TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)
	) u_rx (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.rx_line(data_s1[0]),
		.sync_en(sync_en_q),
		.period (period),
		.res    (rx_res)
	);

endmodule
